// ===== rtl/core/bsc_pkg.sv =====
// Shared constants and types for the Bhaskara sine/cosine block.
`default_nettype none
package bsc_pkg;

   localparam int ANGLE_W = 16;           // signed Q3.12 angle
   localparam int SUM_W   = ANGLE_W + 1;  // angle plus quarter-turn offset
   localparam int X_W     = 14;           // magnitude, never above pi
   localparam int P_W     = 26;           // x*(pi-x), at most (pi/2)^2 in Q.24
   localparam int REM_W   = 30;           // divider remainder and divisor
   localparam int QUO_W   = 15;           // quotient bits, peak result is 2^14
   localparam int VAL_W   = 16;           // signed Q1.14 result

   // Q.12 angle constants
   localparam logic signed [SUM_W-1:0] PI_S      = SUM_W'(12868);
   localparam logic signed [SUM_W-1:0] NEG_PI_S  = SUM_W'(-12868);
   localparam logic signed [SUM_W-1:0] HALF_PI_S = SUM_W'(6434);
   localparam logic signed [SUM_W-1:0] TWO_PI_S  = SUM_W'(25736);
   localparam logic signed [SUM_W-1:0] FOUR_PI_S = SUM_W'(51472);
   localparam logic [X_W-1:0]          PI_X      = X_W'(12868);

   // 5*pi^2 in Q.24
   localparam logic [REM_W-1:0] DEN_BASE = REM_W'(827927120);

   localparam logic OP_SINE   = 1'b0;
   localparam logic OP_COSINE = 1'b1;

   // Word handed from cell to cell along the divider row
   typedef struct packed {
      logic             neg;
      logic [REM_W-1:0] den;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } bsc_div_type;

endpackage
`default_nettype wire

// ===== rtl/core/bhaskara_sine_cosine_top.sv =====
// Bhaskara sine/cosine approximation: Q3.12 radians in, Q1.14 value out, one request per cycle.
// Four front stages (offset, wrap and magnitude, product, divisor) feed a row of fifteen
// divider cells, one quotient bit per cell. A new request enters every cycle while the
// result side keeps up; each stage holds its request only while the stage behind it is
// full and stalled, so bubbles close up and the last cell serves as the output register.
`default_nettype none
module bhaskara_sine_cosine_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_type,
   input  wire logic signed [bsc_pkg::ANGLE_W-1:0]  req_angle,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [bsc_pkg::VAL_W-1:0]         rsp_value
);

   logic                    chain_valid [bsc_pkg::QUO_W+1];
   logic                    chain_ready [bsc_pkg::QUO_W+1];
   bsc_pkg::bsc_div_type    chain_data  [bsc_pkg::QUO_W+1];
   bsc_pkg::bsc_div_type    last;
   logic [bsc_pkg::VAL_W-1:0] mag;

   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_type   (req_type),
      .in_angle  (req_angle),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < bsc_pkg::QUO_W; i++) begin : g_cell
      bsc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign last                           = chain_data[bsc_pkg::QUO_W];
   assign chain_ready[bsc_pkg::QUO_W]    = rsp_ready;
   assign rsp_valid                      = chain_valid[bsc_pkg::QUO_W];

   // apply the sign after truncating the magnitude
   assign mag       = {1'b0, last.quo};
   assign rsp_value = last.neg ? -mag : mag;

endmodule
`default_nettype wire

// ===== rtl/core/bsc_front.sv =====
// Front end: quarter-turn offset, range wrap, magnitude, product and divisor.
`default_nettype none
module bsc_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic                                in_type,
   input  wire logic signed [bsc_pkg::ANGLE_W-1:0]  in_angle,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output bsc_pkg::bsc_div_type                     out_data
);

   logic adv1, adv2, adv3, adv4;

   logic                                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [bsc_pkg::SUM_W-1:0]     s1_sum_ff;
   logic signed [bsc_pkg::SUM_W-1:0]     s1_sum_in;
   logic                                 s2_neg_ff, s3_neg_ff;
   logic [bsc_pkg::X_W-1:0]              s2_x_ff;
   logic [bsc_pkg::X_W-1:0]              s2_x_in;
   logic                                 s2_neg_in;
   logic [bsc_pkg::P_W-1:0]              s3_p_ff;
   logic [2*bsc_pkg::X_W-1:0]            prod;
   logic [bsc_pkg::X_W-1:0]              pmx;
   bsc_pkg::bsc_div_type                 s4_data_ff;
   bsc_pkg::bsc_div_type                 s4_data_in;

   logic signed [bsc_pkg::SUM_W-1:0]     sub1, sub2, add1, wrapped;
   logic [bsc_pkg::SUM_W-1:0]            mag;

   assign adv4     = !s4_valid_ff || out_ready;
   assign adv3     = !s3_valid_ff || adv4;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   // cosine is sine shifted by a quarter turn
   assign s1_sum_in = {in_angle[bsc_pkg::ANGLE_W-1], in_angle}
                    + ((in_type == bsc_pkg::OP_COSINE) ? bsc_pkg::HALF_PI_S
                                                       : bsc_pkg::SUM_W'(0));

   // at this width at most two turns come off the top and one goes onto the bottom
   assign sub1 = s1_sum_ff - bsc_pkg::TWO_PI_S;
   assign sub2 = s1_sum_ff - bsc_pkg::FOUR_PI_S;
   assign add1 = s1_sum_ff + bsc_pkg::TWO_PI_S;

   always_comb begin
      if (s1_sum_ff > bsc_pkg::PI_S) begin
         wrapped = (sub1 > bsc_pkg::PI_S) ? sub2 : sub1;
      end else if (s1_sum_ff < bsc_pkg::NEG_PI_S) begin
         wrapped = add1;
      end else begin
         wrapped = s1_sum_ff;
      end
   end

   assign mag       = wrapped[bsc_pkg::SUM_W-1] ? bsc_pkg::SUM_W'(-wrapped) : wrapped;
   assign s2_x_in   = mag[bsc_pkg::X_W-1:0];
   assign s2_neg_in = wrapped[bsc_pkg::SUM_W-1];

   assign pmx  = bsc_pkg::PI_X - s2_x_ff;
   assign prod = s2_x_ff * pmx;

   // numerator 16*p<<14 over a divisor below 2^30: its top part is p<<3 and the
   // low fifteen bits shifted into the divider are all zero
   always_comb begin
      s4_data_in.neg = s3_neg_ff;
      s4_data_in.rem = {1'b0, s3_p_ff, 3'b000};
      s4_data_in.den = bsc_pkg::DEN_BASE - {2'b00, s3_p_ff, 2'b00};
      s4_data_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= in_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
         if (adv4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         s1_sum_ff <= s1_sum_in;
      end
      if (adv2 && s1_valid_ff) begin
         s2_x_ff   <= s2_x_in;
         s2_neg_ff <= s2_neg_in;
      end
      if (adv3 && s2_valid_ff) begin
         s3_p_ff   <= prod[bsc_pkg::P_W-1:0];
         s3_neg_ff <= s2_neg_ff;
      end
      if (adv4 && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bsc_div_cell.sv =====
// One divider cell: shifts the remainder, tries the divisor, keeps one quotient bit.
`default_nettype none
module bsc_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire bsc_pkg::bsc_div_type  in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output bsc_pkg::bsc_div_type       out_data
);

   logic                          valid_ff;
   bsc_pkg::bsc_div_type          data_ff;
   bsc_pkg::bsc_div_type          data_in;
   logic [bsc_pkg::REM_W:0]       rem_sh;
   logic [bsc_pkg::REM_W:0]       diff;
   logic                          fits;

   assign rem_sh = {in_data.rem, 1'b0};
   assign diff   = rem_sh - {1'b0, in_data.den};
   assign fits   = rem_sh >= {1'b0, in_data.den};

   // remainder stays below the divisor, so it drops back to REM_W bits
   always_comb begin
      data_in     = in_data;
      data_in.rem = fits ? diff[bsc_pkg::REM_W-1:0] : rem_sh[bsc_pkg::REM_W-1:0];
      data_in.quo = {in_data.quo[bsc_pkg::QUO_W-2:0], fits};
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/bsc_checker.sv =====
// Port-level checks for the Bhaskara sine/cosine block, bound to the top level.
`default_nettype none
module bsc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                req_type,
   input wire logic signed [bsc_pkg::ANGLE_W-1:0]  req_angle,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [bsc_pkg::VAL_W-1:0]    rsp_value
);

   // drop any result during and right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // hold a waiting request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_type) && $stable(req_angle))
      else $error("waiting request changed");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result changed");

   // results stay within plus or minus one in Q1.14
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= 16'sd16384) && (rsp_value >= -16'sd16384))
      else $error("result out of range");

   // after reset, a first cycle with no result is followed by the cycle after it with no result either
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !rsp_valid ##1 1'b1 |-> !rsp_valid)
      else $error("result too early after reset");

endmodule

bind bhaskara_sine_cosine_top bsc_checker u_bsc_checker (.*);
`default_nettype wire

// ===== sim/bhaskara_sine_cosine_top_tb.sv =====
// Self-checking testbench for the Bhaskara sine/cosine block.
`timescale 1ns / 100ps
module bhaskara_sine_cosine_top_tb;

   localparam int ANGLE_W    = bsc_pkg::ANGLE_W;
   localparam int VAL_W      = bsc_pkg::VAL_W;
   localparam int PI_Q12     = 12868;
   localparam int HALF_Q12   = 6434;
   localparam int TWO_PI_Q12 = 25736;
   localparam int RAND_ITEMS = 600;
   localparam int IDLE_LIMIT = 1000;
   localparam int TAIL_WAIT  = 40;

   localparam logic signed [ANGLE_W-1:0] A_PI     = 16'sd12868;
   localparam logic signed [ANGLE_W-1:0] A_HALF   = 16'sd6434;
   localparam logic signed [ANGLE_W-1:0] A_TWO_PI = 16'sd25736;
   localparam logic signed [VAL_W-1:0]   ONE_Q14  = 16'sd16384;

   localparam logic KNOWN   = 1'b1;
   localparam logic PREDICT = 1'b0;

   typedef struct packed {
      logic                      op;
      logic signed [ANGLE_W-1:0] angle;
      logic                      known;
      logic signed [VAL_W-1:0]   value;
   } dir_row_type;

   localparam int DIR_ROWS_N = 24;
   localparam dir_row_type DIR_ROWS [DIR_ROWS_N] = '{
      '{bsc_pkg::OP_SINE,   16'sd0,           KNOWN,   16'sd0},
      '{bsc_pkg::OP_SINE,   A_HALF,           KNOWN,   ONE_Q14},
      '{bsc_pkg::OP_SINE,   -A_HALF,          KNOWN,   -ONE_Q14},
      '{bsc_pkg::OP_SINE,   A_PI,             KNOWN,   16'sd0},
      '{bsc_pkg::OP_SINE,   -A_PI,            KNOWN,   16'sd0},
      '{bsc_pkg::OP_SINE,   A_TWO_PI,         KNOWN,   16'sd0},
      '{bsc_pkg::OP_SINE,   -A_TWO_PI,        KNOWN,   16'sd0},
      '{bsc_pkg::OP_COSINE, 16'sd0,           KNOWN,   ONE_Q14},
      '{bsc_pkg::OP_COSINE, -A_HALF,          KNOWN,   16'sd0},
      '{bsc_pkg::OP_COSINE, A_HALF,           KNOWN,   16'sd0},
      '{bsc_pkg::OP_COSINE, A_PI,             KNOWN,   -ONE_Q14},
      '{bsc_pkg::OP_COSINE, -A_PI,            KNOWN,   -ONE_Q14},
      // lands exactly on -pi after the offset
      '{bsc_pkg::OP_COSINE, -A_PI - A_HALF,   KNOWN,   16'sd0},
      '{bsc_pkg::OP_SINE,   16'sh7FFF,        PREDICT, 16'sd0},
      '{bsc_pkg::OP_SINE,   16'sh8000,        PREDICT, 16'sd0},
      // two wrap steps
      '{bsc_pkg::OP_COSINE, 16'sh7FFF,        PREDICT, 16'sd0},
      '{bsc_pkg::OP_COSINE, 16'sh8000,        PREDICT, 16'sd0},
      '{bsc_pkg::OP_SINE,   A_PI + 16'sd1,    PREDICT, 16'sd0},
      '{bsc_pkg::OP_SINE,   -A_PI - 16'sd1,   PREDICT, 16'sd0},
      '{bsc_pkg::OP_COSINE, A_HALF + 16'sd1,  PREDICT, 16'sd0},
      '{bsc_pkg::OP_SINE,   16'sd1,           PREDICT, 16'sd0},
      '{bsc_pkg::OP_SINE,   -16'sd1,          PREDICT, 16'sd0},
      '{bsc_pkg::OP_COSINE, 16'sh5555,        PREDICT, 16'sd0},
      '{bsc_pkg::OP_SINE,   16'shAAAA,        PREDICT, 16'sd0}
   };

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_type;
   logic signed [ANGLE_W-1:0] req_angle;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [VAL_W-1:0]   rsp_value;

   // stimulus side bookkeeping, held alongside the request payload
   logic                      drv_known;
   logic signed [VAL_W-1:0]   drv_value;

   logic signed [VAL_W-1:0] pending_values[$];
   int req_count = 0;
   int value_count = 0;
   int sine_count = 0;
   int cosine_count = 0;
   int negative_count = 0;
   int error_count = 0;
   int idle_cycles = 0;

   bhaskara_sine_cosine_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_angle (req_angle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Q1.14 Bhaskara value for a Q3.12 angle
   function automatic logic signed [VAL_W-1:0] bhaskara_value(
      input logic op, input logic signed [ANGLE_W-1:0] angle);
      longint          a;
      longint unsigned x;
      longint unsigned p;
      longint unsigned num;
      longint unsigned den;
      longint unsigned mag;
      logic            neg;
      a = angle;
      if (op == bsc_pkg::OP_COSINE) a = a + HALF_Q12;
      while (a > PI_Q12) a = a - TWO_PI_Q12;
      while (a < -PI_Q12) a = a + TWO_PI_Q12;
      neg = (a < 0);
      x = neg ? longint'(-a) : longint'(a);
      p = x * (longint'(PI_Q12) - x);
      num = (p * 16) << 14;
      den = longint'(5) * PI_Q12 * PI_Q12 - 4 * p;
      mag = num / den;
      return VAL_W'(neg ? -longint'(mag) : longint'(mag));
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      int r;
      int base;
      r = $urandom_range(0, 99);
      if (r < 60) return ANGLE_W'($urandom());
      if (r < 80) begin
         case ($urandom_range(0, 6))
            0: base = 0;
            1: base = HALF_Q12;
            2: base = -HALF_Q12;
            3: base = PI_Q12;
            4: base = -PI_Q12;
            5: base = TWO_PI_Q12;
            default: base = -TWO_PI_Q12;
         endcase
         return ANGLE_W'(base + $urandom_range(0, 8) - 4);
      end
      if (r < 90) begin
         if ($urandom_range(0, 1) == 1) return ANGLE_W'(32767 - $urandom_range(0, 7));
         return ANGLE_W'(-32768 + $urandom_range(0, 7));
      end
      return ANGLE_W'($urandom_range(0, 128) - 64);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      $display("%0t: mismatch %0d: %s", $realtime, error_count, msg);
   endtask

   // present one request at a falling edge, return at the falling edge after it is taken
   task automatic send_request(input logic op, input logic signed [ANGLE_W-1:0] angle,
                               input logic known, input logic signed [VAL_W-1:0] value,
                               input int gap);
      int target;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_angle <= angle;
      drv_known <= known;
      drv_value <= value;
      target = req_count + 1;
      do @(negedge clock); while (req_count != target);
   endtask

   // hold off new requests until the pipeline has returned everything
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_values.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   initial begin : rsp_side
      int   hold;
      logic level;
      rsp_ready = 1'b0;
      hold = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            level = !level;
            if (!level) hold = idle_len();
            if (!level && hold == 0) level = 1'b1;
            if (level) begin
               hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 20);
            end
         end
         rsp_ready <= level;
         hold--;
      end
   end

   always @(posedge clock) begin : monitor
      logic signed [VAL_W-1:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_values.size() == 0) begin
               report_error($sformatf("unexpected value %0d", rsp_value));
            end else begin
               want = pending_values.pop_front();
               if (rsp_value !== want)
                  report_error($sformatf("value %0d, expected %0d", rsp_value, want));
               if (want < 0) negative_count++;
            end
            value_count++;
         end
         if (req_valid && req_ready) begin
            want = drv_known ? drv_value : bhaskara_value(req_type, req_angle);
            pending_values.push_back(want);
            if (req_type == bsc_pkg::OP_COSINE) cosine_count++;
            else sine_count++;
            req_count <= req_count + 1;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      logic burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = bsc_pkg::OP_SINE;
      req_angle = '0;
      drv_known = PREDICT;
      drv_value = '0;
      burst = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS_N; i++) begin
         send_request(DIR_ROWS[i].op, DIR_ROWS[i].angle, DIR_ROWS[i].known,
                      DIR_ROWS[i].value, idle_len());
      end

      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
         if (i > 0 && i % 200 == 0) drain_pipeline();
         send_request(logic'($urandom_range(0, 1)), random_angle(), PREDICT, '0,
                      burst ? 0 : idle_len());
      end
      req_valid <= 1'b0;

      while (pending_values.size() != 0) @(negedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (pending_values.size() != 0)
         report_error($sformatf("%0d values never returned", pending_values.size()));

      $display("Sent %0d sine and %0d cosine requests, directed edges and random angles;",
               sine_count, cosine_count);
      $display("checked %0d values (%0d negative) under random stalls on both sides.",
               value_count, negative_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bsc_pkg.sv
rtl/core/bsc_front.sv
rtl/core/bsc_div_cell.sv
rtl/core/bhaskara_sine_cosine_top.sv
rtl/core/bsc_checker.sv
sim/bhaskara_sine_cosine_top_tb.sv
